// ===== src/rfb_pkg.sv =====
// shared types and codes for the ring fifo / four-slot buffer
package rfb_pkg;

  localparam int DATA_W = 64;
  localparam int SIZE_W = 7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic MODE_RING = 1'b0;
  localparam logic MODE_SLOT = 1'b1;

  localparam logic REG_MODE      = 1'b0;
  localparam logic REG_RING_SIZE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] write_data;
  } cmd_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [1:0]        status;
  } res_beat_t;

  typedef struct packed {
    logic req;
    logic is_read;
  } acc_t;

  typedef struct packed {
    logic [1:0] status;
    logic       mem_hit;
  } ring_rsp_t;

endpackage

// ===== src/rfb_ring.sv =====
// ring fifo: index and count control plus the ring memory
module rfb_ring
  import rfb_pkg::*;
#(
  parameter int RING_DEPTH   = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  acc_t                    acc,
  input  logic [PAYLOAD_BITS-1:0] wdata,
  input  logic [SIZE_W-1:0]       size_cfg,
  output ring_rsp_t               rsp,
  output logic [PAYLOAD_BITS-1:0] rd_data
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SZ_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [PAYLOAD_BITS-1:0] mem [RING_DEPTH];

  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;

  logic [SZ_W-1:0]  size_wide;
  logic [CNT_W-1:0] size_use;
  logic [CNT_W-1:0] widx_inc, ridx_inc;
  logic             full, empty, do_wr, do_rd;

  assign size_wide = SZ_W'(size_cfg);

  always_comb begin
    if (size_cfg == '0) begin
      size_use = CNT_W'(1);
    end else if (size_wide > SZ_W'(RING_DEPTH)) begin
      size_use = CNT_W'(RING_DEPTH);
    end else begin
      size_use = CNT_W'(size_wide);
    end
  end

  assign full  = entry_count >= size_use;
  assign empty = entry_count == '0;
  assign do_wr = acc.req && !acc.is_read && !full;
  assign do_rd = acc.req && acc.is_read && !empty;

  assign widx_inc = CNT_W'(write_index) + CNT_W'(1);
  assign ridx_inc = CNT_W'(read_index) + CNT_W'(1);

  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    entry_count_next = entry_count;
    if (do_wr) begin
      write_index_next = (widx_inc >= size_use) ? '0 : widx_inc[IDX_W-1:0];
      entry_count_next = entry_count + CNT_W'(1);
    end
    if (do_rd) begin
      read_index_next  = (ridx_inc >= size_use) ? '0 : ridx_inc[IDX_W-1:0];
      entry_count_next = entry_count - CNT_W'(1);
    end
  end

  always_comb begin
    rsp.status  = ST_DONE;
    rsp.mem_hit = do_rd;
    if (acc.req && acc.is_read && empty) begin
      rsp.status = ST_EMPTY;
    end else if (acc.req && !acc.is_read && full) begin
      rsp.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      entry_count <= '0;
    end else begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[write_index] <= wdata;
    end
    if (do_rd) begin
      rd_data <= mem[read_index];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(RING_DEPTH))
    else $error("ring count past depth");

  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    acc.req && acc.is_read && empty |=> entry_count == '0 && $stable(read_index))
    else $error("refused read moved ring state");

  a_write_count: assert property (@(posedge clk) disable iff (rst)
    do_wr |=> entry_count == CNT_W'($past(entry_count) + CNT_W'(1)))
    else $error("accepted write did not bump count");

endmodule

// ===== src/rfb_slot.sv =====
// four-slot latest-value buffer: slot store and pair bookkeeping
module rfb_slot
  import rfb_pkg::*;
#(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  acc_t                    acc,
  input  logic [PAYLOAD_BITS-1:0] wdata,
  output logic [PAYLOAD_BITS-1:0] rd_data
);

  logic [PAYLOAD_BITS-1:0] slot_store [4];
  logic                    latest_pair;
  logic                    reading_pair;
  logic [1:0]              pair_slot;

  logic       wr_pair, wr_slot;
  logic [1:0] rd_sel, wr_sel;

  assign rd_sel  = {latest_pair, pair_slot[latest_pair]};
  assign wr_pair = ~reading_pair;
  assign wr_slot = ~pair_slot[wr_pair];
  assign wr_sel  = {wr_pair, wr_slot};
  assign rd_data = slot_store[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        slot_store[i] <= '0;
      end
      latest_pair  <= 1'b0;
      reading_pair <= 1'b0;
      pair_slot    <= '0;
    end else if (acc.req) begin
      if (acc.is_read) begin
        reading_pair <= latest_pair;
      end else begin
        slot_store[wr_sel]  <= wdata;
        pair_slot[wr_pair]  <= wr_slot;
        latest_pair         <= wr_pair;
      end
    end
  end

endmodule

// ===== src/ring_fifo_or_four_slot_buffer.sv =====
// top level: ring fifo or four-slot buffer with config registers and output stage
//
//   channel   dir  handshake             payload
//   cmd       in   cmd_valid/cmd_stall   cmd_beat (cmd, write_data)
//   res       out  res_valid/res_stall   res_beat (read_data, status)
//   cfg       in   cfg_we                cfg_index, cfg_data
//
// one beat per cycle sustained while res_stall is low; each command gives one result
// once it is accepted, through the access stage and then the result register
// the ring memory is read at accept, its registered data joins in the access stage
// reset clears indices, counts, slot store, config registers and valid flags; ring memory is not cleared
// a stalled result holds; cmd_stall rises only when both stages are full
module ring_fifo_or_four_slot_buffer
  import rfb_pkg::*;
#(
  parameter int RING_DEPTH   = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_beat_t         cmd_beat,
  output logic              res_valid,
  input  logic              res_stall,
  output res_beat_t         res_beat,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  logic              mode;
  logic [SIZE_W-1:0] ring_size;

  logic                    accept, res_take, s1_move;
  logic [PAYLOAD_BITS-1:0] word;
  acc_t                    ring_acc, slot_acc;
  ring_rsp_t               ring_rsp;
  logic [PAYLOAD_BITS-1:0] ring_rd, slot_rd;

  logic                    s1_valid;
  logic [1:0]              s1_status;
  logic                    s1_mem;
  logic [PAYLOAD_BITS-1:0] s1_data;
  logic [DATA_W-1:0]       out_data;

  assign res_take  = !res_valid || !res_stall;
  assign s1_move   = s1_valid && res_take;
  assign cmd_stall = s1_valid && !res_take;
  assign accept    = cmd_valid && !cmd_stall;
  assign word      = cmd_beat.write_data[PAYLOAD_BITS-1:0];

  assign ring_acc.req     = accept && (mode == MODE_RING);
  assign ring_acc.is_read = cmd_beat.cmd == CMD_READ;
  assign slot_acc.req     = accept && (mode == MODE_SLOT);
  assign slot_acc.is_read = cmd_beat.cmd == CMD_READ;

  rfb_ring #(
    .RING_DEPTH  (RING_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .acc     (ring_acc),
    .wdata   (word),
    .size_cfg(ring_size),
    .rsp     (ring_rsp),
    .rd_data (ring_rd)
  );

  rfb_slot #(
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_slot (
    .clk    (clk),
    .rst    (rst),
    .acc    (slot_acc),
    .wdata  (word),
    .rd_data(slot_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RING;
      ring_size <= SIZE_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:      mode      <= cfg_data[0];
        REG_RING_SIZE: ring_size <= cfg_data;
        default:       mode      <= mode;
      endcase
    end
  end

  // access stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (mode == MODE_SLOT) begin
        s1_status <= ST_DONE;
        s1_mem    <= 1'b0;
        s1_data   <= (cmd_beat.cmd == CMD_READ) ? slot_rd : '0;
      end else begin
        s1_status <= ring_rsp.status;
        s1_mem    <= ring_rsp.mem_hit;
        s1_data   <= '0;
      end
    end
  end

  always_comb begin
    out_data = '0;
    out_data[PAYLOAD_BITS-1:0] = s1_mem ? ring_rd : s1_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_take) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_beat.read_data <= out_data;
      res_beat.status    <= s1_status;
    end
  end

endmodule
